@@ sv/terminal_cursor_tracker_defines.svh @@
// Assertion macros for the cursor tracker top level.
`ifndef TERMINAL_CURSOR_TRACKER_DEFINES_SVH
`define TERMINAL_CURSOR_TRACKER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/tct_pkg.sv @@
// Types and constants shared by the terminal cursor tracker modules.
package tct_pkg;

  localparam int POS_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int MAX_SPACES  = 8;
  localparam int SPACE_CNT_W = 4;

  localparam logic [POS_W-1:0]  POS_MAX    = '1;
  localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_USE_LAST_CELL = 3'd2,
    CFG_WRAP_ENABLE   = 3'd3,
    CFG_CR_BEFORE_LF  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] screen_width;
    logic [BYTE_W-1:0] screen_height;
    logic              use_last_cell;
    logic              wrap_enable;
    logic              cr_before_lf;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_INC_SAT   = 2'd0,
    ALU_DEC_FLOOR = 2'd1,
    ALU_SUB       = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [POS_W-1:0] value;
    logic             carry;
  } alu_res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              accepted;
    logic [POS_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_col;
    logic              last_result;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CR,
    S_CHECK,
    S_MOD,
    S_TAB_INIT,
    S_TAB_COND,
    S_TAB_INC,
    S_WRAP,
    S_WRAP_ROW,
    S_FINAL
  } state_t;

endpackage

@@ sv/terminal_cursor_tracker.sv @@
// Top level of the terminal cursor tracker: configuration, sequencer and output register.
//
// Each character item is taken on the input stream and turned into one or more result
// items on the output stream, each carrying the byte to send and the cursor position
// after it; tlast marks the final result of a character. The block works on one
// character at a time and is not ready while it does. A line feed with a leading
// carriage return first sends the carriage return in its own state, a wrap that moves
// the cursor to the next row takes an extra row step, backspace skips the wrap check and
// a refused character returns to idle with its single result. A tab first forms the
// quotient of the column by TAB_STOP through a reciprocal multiplication, then the
// distance to the next stop in the shared adder, and each space needs an increment and
// a compare step in that same adder. Results leave through a one-item output register,
// so the sequencer stalls only when that register is full and not being drained.
// Configuration writes are always taken and must be made while no character is in
// progress.
`include "terminal_cursor_tracker_defines.svh"

module terminal_cursor_tracker #(
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [23:8] cursor_row, [39:24] cursor_col
  output logic [1:0]  m_axis_tuser,   // [0] has_byte, [1] accepted
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tct_pkg::*;

  cfg_t    cfg;
  logic    emit_valid;
  logic    emit_ready;
  result_t emit;
  logic    out_valid;
  result_t out_item;

  tct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tct_ctrl #(
    .TAB_STOP (TAB_STOP)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_char    (s_axis_tdata),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit       (emit)
  );

  assign emit_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_item <= emit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_item.cursor_col, out_item.cursor_row, out_item.out_byte};
  assign m_axis_tuser  = {out_item.accepted, out_item.has_byte};
  assign m_axis_tlast  = out_item.last_result;

  `TCT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "input ready straight after an item was taken")
  `TCT_ASSERT_NEXT(a_ready_after_last, emit_valid && emit_ready && emit.last_result,
                   s_axis_tready, "not ready after the final result of an item")
  `TCT_ASSERT_NOW(a_no_emit_when_idle, emit_valid, !s_axis_tready,
                  "result produced while waiting for input")

endmodule

@@ sv/tct_cfg.sv @@
// Configuration register bank of the terminal cursor tracker.
module tct_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tct_pkg::BYTE_W-1:0]      cfg_data,
  output tct_pkg::cfg_t                   cfg
);
  import tct_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 8'd80;
      cfg.screen_height <= 8'd24;
      cfg.use_last_cell <= 1'b0;
      cfg.wrap_enable   <= 1'b0;
      cfg.cr_before_lf  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        CFG_USE_LAST_CELL: cfg.use_last_cell <= cfg_data[0];
        CFG_WRAP_ENABLE:   cfg.wrap_enable   <= cfg_data[0];
        CFG_CR_BEFORE_LF:  cfg.cr_before_lf  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/tct_alu.sv @@
// Shared adder of the cursor tracker: saturating increment, floored decrement, subtract.
module tct_alu (
  input  tct_pkg::alu_op_t            op,
  input  logic [tct_pkg::POS_W-1:0]   a,
  input  logic [tct_pkg::POS_W-1:0]   b,
  output tct_pkg::alu_res_t           res
);
  import tct_pkg::*;

  logic [POS_W-1:0] b_eff;
  logic             cin;
  logic [POS_W:0]   sum;

  always_comb begin
    b_eff = '0;
    cin   = 1'b0;
    unique case (op)
      ALU_INC_SAT: begin
        b_eff = '0;
        cin   = 1'b1;
      end
      ALU_DEC_FLOOR: begin
        b_eff = '1;
        cin   = 1'b0;
      end
      ALU_SUB: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
      default: begin
        b_eff = '0;
        cin   = 1'b0;
      end
    endcase
    sum       = {1'b0, a} + {1'b0, b_eff} + {{POS_W{1'b0}}, cin};
    res.carry = sum[POS_W];
    res.value = sum[POS_W-1:0];
    if ((op == ALU_INC_SAT) && (a == POS_MAX)) begin
      res.value = a;
    end
    if ((op == ALU_DEC_FLOOR) && (a == '0)) begin
      res.value = a;
    end
  end

endmodule

@@ sv/tct_ctrl.sv @@
// Sequencer of the cursor tracker: holds the cursor and steps the shared adder per item.
module tct_ctrl #(
  parameter int TAB_STOP = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tct_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tct_pkg::BYTE_W-1:0]    in_char,
  output logic                          emit_valid,
  input  logic                          emit_ready,
  output tct_pkg::result_t              emit
);
  import tct_pkg::*;

  localparam int REM_W     = $clog2(TAB_STOP);
  localparam int CNT_W     = $clog2(TAB_STOP + 1);
  localparam int MUL_SHIFT = POS_W + REM_W;
  localparam int RECIP_W   = POS_W + 1;
  localparam logic [POS_W-1:0]   TAB_STOP_W = POS_W'(TAB_STOP);
  localparam logic [RECIP_W-1:0] RECIP      =
    RECIP_W'((64'd1 << MUL_SHIFT) / 64'(TAB_STOP) + 64'd1);

  state_t                 state, state_next;
  logic [BYTE_W-1:0]      char_reg, char_reg_next;
  logic [POS_W-1:0]       row, row_next;
  logic [POS_W-1:0]       col, col_next;
  logic [POS_W-1:0]       quot, quot_next;
  logic [CNT_W-1:0]       tab_left, tab_left_next;
  logic [SPACE_CNT_W-1:0] spaces, spaces_next;

  alu_op_t                alu_op;
  logic [POS_W-1:0]       alu_a;
  logic [POS_W-1:0]       alu_b;
  alu_res_t               alu_res;

  logic [POS_W-1:0]       width_ext;
  logic [BYTE_W-1:0]      width_m1;
  logic [BYTE_W-1:0]      height_m1;
  logic                   refuse;
  logic [2*POS_W:0]       quot_prod;
  logic [POS_W-1:0]       quot_scaled;
  logic                   tab_go;

  tct_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign width_ext   = POS_W'(cfg.screen_width);
  assign width_m1    = cfg.screen_width - 8'd1;
  assign height_m1   = cfg.screen_height - 8'd1;
  assign refuse      = !cfg.use_last_cell && (cfg.screen_height != '0) &&
                       (cfg.screen_width != '0) && (row == POS_W'(height_m1)) &&
                       (col == POS_W'(width_m1));
  assign quot_prod   = {{(POS_W+1){1'b0}}, col} * {{POS_W{1'b0}}, RECIP};
  assign quot_scaled = quot * TAB_STOP_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    char_reg <= char_reg_next;
    quot     <= quot_next;
    tab_left <= tab_left_next;
    spaces   <= spaces_next;
  end

  always_comb begin
    state_next       = state;
    char_reg_next    = char_reg;
    row_next         = row;
    col_next         = col;
    quot_next        = quot;
    tab_left_next    = tab_left;
    spaces_next      = spaces;
    alu_op           = ALU_SUB;
    alu_a            = col;
    alu_b            = width_ext;
    in_ready         = 1'b0;
    emit_valid       = 1'b0;
    emit.out_byte    = '0;
    emit.has_byte    = 1'b0;
    emit.accepted    = 1'b1;
    emit.cursor_row  = row;
    emit.cursor_col  = col;
    emit.last_result = 1'b0;
    tab_go           = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          char_reg_next = in_char;
          if (cfg.cr_before_lf && (in_char == CHAR_LF)) begin
            state_next = S_CR;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CR: begin
        emit_valid    = 1'b1;
        emit.out_byte = CHAR_CR;
        emit.has_byte = 1'b1;
        if (emit_ready) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        spaces_next = '0;
        if (refuse) begin
          emit_valid       = 1'b1;
          emit.accepted    = 1'b0;
          emit.last_result = 1'b1;
          if (emit_ready) begin
            state_next = S_IDLE;
          end
        end else begin
          unique case (char_reg)
            CHAR_LF: begin
              alu_op     = ALU_INC_SAT;
              alu_a      = row;
              row_next   = alu_res.value;
              col_next   = '0;
              state_next = S_WRAP;
            end
            CHAR_CR: begin
              col_next   = '0;
              state_next = S_WRAP;
            end
            CHAR_BS: begin
              alu_op     = ALU_DEC_FLOOR;
              col_next   = alu_res.value;
              state_next = S_FINAL;
            end
            CHAR_TAB: begin
              state_next = S_MOD;
            end
            default: begin
              alu_op     = ALU_INC_SAT;
              col_next   = alu_res.value;
              state_next = S_WRAP;
            end
          endcase
        end
      end
      S_MOD: begin
        // The quotient of the column by the tab stop comes from a reciprocal multiplication.
        quot_next  = POS_W'(quot_prod >> MUL_SHIFT);
        state_next = S_TAB_INIT;
      end
      S_TAB_INIT: begin
        alu_b         = quot_scaled;
        tab_left_next = CNT_W'(TAB_STOP) - CNT_W'(alu_res.value[REM_W-1:0]);
        state_next    = S_TAB_COND;
      end
      S_TAB_COND: begin
        tab_go = (cfg.wrap_enable || !alu_res.carry) && (tab_left != '0) &&
                 (spaces != SPACE_CNT_W'(MAX_SPACES));
        if (tab_go) begin
          // The previous space goes out now; the last one waits for the wrap step.
          if (spaces != '0) begin
            emit_valid    = 1'b1;
            emit.out_byte = CHAR_SPACE;
            emit.has_byte = 1'b1;
            if (emit_ready) begin
              state_next = S_TAB_INC;
            end
          end else begin
            state_next = S_TAB_INC;
          end
        end else begin
          state_next = S_WRAP;
        end
      end
      S_TAB_INC: begin
        alu_op        = ALU_INC_SAT;
        col_next      = alu_res.value;
        tab_left_next = tab_left - CNT_W'(1);
        spaces_next   = spaces + SPACE_CNT_W'(1);
        state_next    = S_TAB_COND;
      end
      S_WRAP: begin
        if (cfg.wrap_enable && alu_res.carry) begin
          col_next   = alu_res.value;
          state_next = S_WRAP_ROW;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_WRAP_ROW: begin
        alu_op     = ALU_INC_SAT;
        alu_a      = row;
        row_next   = alu_res.value;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        emit_valid       = 1'b1;
        emit.last_result = 1'b1;
        if (char_reg != CHAR_TAB) begin
          emit.out_byte = char_reg;
          emit.has_byte = 1'b1;
        end else if (spaces != '0) begin
          emit.out_byte = CHAR_SPACE;
          emit.has_byte = 1'b1;
        end
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ test/cursor_checker.sv @@
// Checker for the terminal cursor tracker: predicts the result items of each character and compares them.
module cursor_checker #(
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatch_count,
  output int          results_owed,
  output logic [15:0] row_now
);
  timeunit 1ns;
  timeprecision 1ps;
  import tct_pkg::*;

  localparam logic [7:0] WIDTH_AT_RESET  = 8'd80;
  localparam logic [7:0] HEIGHT_AT_RESET = 8'd24;
  localparam int         MOST_RESULTS    = 8;
  localparam int         PRINT_LIMIT     = 40;

  cfg_t             screen;
  logic [POS_W-1:0] cur_row;
  logic [POS_W-1:0] cur_col;
  result_t          batch [MOST_RESULTS];
  int               batch_len;
  result_t          owed_results [$];

  function automatic logic [POS_W-1:0] step_up(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("%0t cursor_checker: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input int unsigned seen,
                             input int unsigned owed);
    if (seen != owed) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", field, seen, owed));
    end
  endtask

  task automatic add_result(input logic [7:0] b, input logic has, input logic acc);
    batch[batch_len].out_byte    = b;
    batch[batch_len].has_byte    = has;
    batch[batch_len].accepted    = acc;
    batch[batch_len].cursor_row  = cur_row;
    batch[batch_len].cursor_col  = cur_col;
    batch[batch_len].last_result = 1'b0;
    batch_len++;
  endtask

  // Works out the result items that one character causes and queues them in order.
  task automatic expand_char(input logic [7:0] c);
    int unsigned left;
    batch_len = 0;
    if (screen.cr_before_lf && c == CHAR_LF) add_result(CHAR_CR, 1'b1, 1'b1);
    if (!screen.use_last_cell && screen.screen_height != 0 && screen.screen_width != 0 &&
        cur_row == POS_W'(screen.screen_height) - 1'b1 &&
        cur_col == POS_W'(screen.screen_width) - 1'b1) begin
      add_result('0, 1'b0, 1'b0);
    end else if (c == CHAR_BS) begin
      if (cur_col != 0) cur_col = cur_col - 1'b1;
      add_result(c, 1'b1, 1'b1);
    end else begin
      case (c)
        CHAR_LF: begin
          cur_row = step_up(cur_row);
          cur_col = '0;
        end
        CHAR_CR: cur_col = '0;
        CHAR_TAB: begin
          left = TAB_STOP - (cur_col % TAB_STOP);
          while ((screen.wrap_enable || cur_col < screen.screen_width) && left > 0 &&
                 batch_len < MOST_RESULTS) begin
            cur_col = step_up(cur_col);
            add_result(CHAR_SPACE, 1'b1, 1'b1);
            left--;
          end
        end
        default: cur_col = step_up(cur_col);
      endcase
      if (screen.wrap_enable && cur_col >= screen.screen_width) begin
        cur_row = step_up(cur_row);
        cur_col = cur_col - screen.screen_width;
      end
      if (c != CHAR_TAB) begin
        add_result(c, 1'b1, 1'b1);
      end else if (batch_len == 0) begin
        add_result('0, 1'b0, 1'b1);
      end else begin
        // The last space of a tab shows the position after the wrap.
        batch[batch_len-1].cursor_row = cur_row;
        batch[batch_len-1].cursor_col = cur_col;
      end
    end
    batch[batch_len-1].last_result = 1'b1;
    for (int i = 0; i < batch_len; i++) owed_results.push_back(batch[i]);
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      screen.screen_width  = WIDTH_AT_RESET;
      screen.screen_height = HEIGHT_AT_RESET;
      screen.use_last_cell = 1'b0;
      screen.wrap_enable   = 1'b0;
      screen.cr_before_lf  = 1'b0;
      cur_row = '0;
      cur_col = '0;
      owed_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:  screen.screen_width  = cfg_data;
          CFG_SCREEN_HEIGHT: screen.screen_height = cfg_data;
          CFG_USE_LAST_CELL: screen.use_last_cell = cfg_data[0];
          CFG_WRAP_ENABLE:   screen.wrap_enable   = cfg_data[0];
          CFG_CR_BEFORE_LF:  screen.cr_before_lf  = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expand_char(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte    = m_axis_tdata[7:0];
        got.cursor_row  = m_axis_tdata[23:8];
        got.cursor_col  = m_axis_tdata[39:24];
        got.has_byte    = m_axis_tuser[0];
        got.accepted    = m_axis_tuser[1];
        got.last_result = m_axis_tlast;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h row %0d col %0d",
                                    got.out_byte, got.cursor_row, got.cursor_col));
        end else begin
          want = owed_results.pop_front();
          check_field("out_byte", got.out_byte, want.out_byte);
          check_field("has_byte", got.has_byte, want.has_byte);
          check_field("accepted", got.accepted, want.accepted);
          check_field("cursor_row", got.cursor_row, want.cursor_row);
          check_field("cursor_col", got.cursor_col, want.cursor_col);
          check_field("last_result", got.last_result, want.last_result);
        end
      end
    end
    results_owed <= owed_results.size();
    row_now      <= cur_row;
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the terminal cursor tracker: drives characters and settings and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tct_pkg::*;

  localparam int TAB_STOP      = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_CHARS   = 29;
  localparam int FILL_CHARS    = 10;
  localparam int TAIL_CHARS    = 20;
  localparam int SETTLE_CYCLES = 30;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic [2:0]  cfg_index     = '0;
  logic [7:0]  cfg_data      = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_ready;

  int          mismatch_count;
  int          results_owed;
  logic [15:0] row_now;
  int unsigned holds_asked = 0;
  int unsigned holds_given = 0;
  bit          steady      = 1'b0;
  int unsigned cycle_count = 0;

  terminal_cursor_tracker #(
    .TAB_STOP(TAB_STOP)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  cursor_checker #(
    .TAB_STOP(TAB_STOP)
  ) results_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed),
    .row_now       (row_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [7:0] random_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return CHAR_TAB;
    if (r < 18) return CHAR_LF;
    if (r < 28) return CHAR_CR;
    if (r < 38) return CHAR_BS;
    if (r < 70) return 8'($urandom_range(126, 32));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_size();
    case ($urandom_range(7))
      0: return 8'd1;
      1: return 8'd255;
      2: return 8'd0;
      default: return 8'($urandom_range(24, 2));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = (steady || $urandom_range(99) < 55) ? 0 : idle_length();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0 || !s_axis_tready);
  endtask

  task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows,
                            input bit last_ok, input bit wrap_on, input bit cr_on);
    cfg_index_t order [5];
    logic [7:0] value [5];
    order = '{CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_USE_LAST_CELL, CFG_WRAP_ENABLE,
              CFG_CR_BEFORE_LF};
    value = '{cols, rows, {7'($urandom), last_ok}, {7'($urandom), wrap_on},
              {7'($urandom), cr_on}};
    // An index past the last register has to be ignored.
    cfg_valid <= 1'b1;
    cfg_index <= 3'(CFG_CR_BEFORE_LF) + 3'($urandom_range(3, 1));
    cfg_data  <= 8'($urandom);
    do @(posedge clk); while (!cfg_ready);
    for (int i = 0; i < 5; i++) begin
      cfg_index <= order[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : sink
    int unsigned stall;
    forever begin
      if (holds_given != holds_asked) begin
        holds_given++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady || $urandom_range(99) < 65) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = idle_length();
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] cols;
    logic [7:0] rows;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_char(8'h00);
    send_char(8'hFF);
    repeat (3) send_char(CHAR_BS);
    send_char(CHAR_TAB);
    send_char(CHAR_CR);
    send_char(CHAR_LF);

    // A narrow screen: tab cut short at the edge, then refusals at the last cell.
    wait_quiet();
    set_screen(8'd5, 8'd3, 1'b0, 1'b0, 1'b1);
    repeat (3) send_char("a");
    repeat (2) send_char(CHAR_TAB);
    send_char(CHAR_LF);
    repeat (4) send_char("b");
    send_char(CHAR_LF);
    send_char("c");

    wait_quiet();
    set_screen(8'd3, 8'd255, 1'b1, 1'b1, 1'b0);
    send_char("d");
    send_char(CHAR_TAB);
    send_char("e");

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_quiet();
      case (p)
        0: begin
          cols = 8'd1;
          rows = 8'd1;
        end
        1: begin
          cols = 8'd255;
          rows = 8'd255;
        end
        2: begin
          cols = 8'd0;
          rows = 8'd0;
        end
        default: begin
          cols = pick_size();
          rows = (row_now < 16'd255 && $urandom_range(1) == 1) ? 8'(row_now + 16'd1)
                                                               : pick_size();
        end
      endcase
      steady = (p % 4 == 3);
      set_screen(cols, rows, 1'($urandom), 1'($urandom), 1'($urandom));
      if (p == 0 || p == 7) holds_asked++;
      for (int k = 0; k < PHASE_CHARS; k++) begin
        if (p == 5 && k == PHASE_CHARS / 2) wait_quiet();
        send_char(random_char());
      end
    end

    // Zero width with wrap on moves the row on every character that reaches the wrap step.
    wait_quiet();
    steady = 1'b1;
    set_screen(8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
    for (int k = 0; k < FILL_CHARS; k++) begin
      send_char(($urandom_range(99) == 0) ? CHAR_TAB : 8'($urandom_range(126, 32)));
    end
    steady = 1'b0;
    for (int k = 0; k < TAIL_CHARS; k++) send_char(random_char());

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/tct_pkg.sv
sv/tct_cfg.sv
sv/tct_alu.sv
sv/tct_ctrl.sv
sv/terminal_cursor_tracker.sv
test/cursor_checker.sv
test/tb.sv
